// ===== src/linear_to_srgb8_pixel_encoder_core_defines.svh =====
// assertion macros for the linear to srgb pixel encoder
`ifndef LINEAR_TO_SRGB8_PIXEL_ENCODER_CORE_DEFINES_SVH
`define LINEAR_TO_SRGB8_PIXEL_ENCODER_CORE_DEFINES_SVH

// checked at every edge, reset included
`define L2S_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) ante |=> cons) \
    else $error("l2s reset check failed");

// same cycle, outside reset
`define L2S_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) ante |-> cons) \
    else $error("l2s check failed");

// next cycle, outside reset
`define L2S_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
    else $error("l2s next-cycle check failed");

`endif

// ===== src/l2s_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2s_pkg
// shared widths, types and threshold tables of the linear to srgb encoder
// ----------------------------------------------------------------------------
package l2s_pkg;

  localparam int SAMPLE_WIDTH  = 32;
  localparam int FRACTION_BITS = 16;

  localparam int LANES   = 3;
  localparam int MAG_W   = SAMPLE_WIDTH - 1;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;
  localparam int PROD_W  = MAG_W + CFG_W;
  localparam int X_W     = 2 * FRACTION_BITS;
  localparam int T_W     = X_W + 1;
  localparam int CODE_W  = 8;
  localparam int CODES   = 256;
  localparam int FC_W    = MAG_W + 9;
  localparam int FCP_W   = CODE_W + 1 + CFG_W;
  localparam int CMP_W   = (FC_W > FCP_W) ? FC_W : FCP_W;
  localparam int NSRCH   = CODE_W;
  localparam int NSTAGE  = 2 + NSRCH;
  localparam int S_TDATA_W = ((LANES * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W = ((LANES * CODE_W + 7) / 8) * 8;
  localparam int BIG_W   = 10 * FRACTION_BITS + 12 * 17 + 8;

  localparam logic [IDX_W-1:0] REG_PREVIEW_MODE  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_EXPOSURE_GAIN = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_PEAK_LEVEL    = IDX_W'(2);

  localparam logic [CFG_W-1:0] GAIN_RESET = CFG_W'(65536);
  localparam logic [CFG_W-1:0] PEAK_RESET = CFG_W'(65536);

  localparam longint unsigned LIN_LIM_FULL = (64'd31308 << X_W) / 64'd10000000;
  localparam logic [X_W-1:0] LIN_LIM = X_W'(LIN_LIM_FULL);

  typedef enum logic [1:0] {
    KIND_LIN,
    KIND_POW,
    KIND_FC
  } kind_t;

  typedef struct packed {
    logic             preview_mode;
    logic [CFG_W-1:0] exposure_gain;
    logic [CFG_W-1:0] peak_level;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic              pos;
    logic              sat;
    logic [X_W-1:0]    x;
    logic [FC_W-1:0]   fc_num;
    logic [CODE_W-1:0] acc;
  } srch_t;

  typedef logic [T_W-1:0] thr_tab_t [CODES];

  // smallest product that reaches each code on the power segment
  function automatic thr_tab_t build_pow_tab();
    thr_tab_t         t;
    logic [BIG_W-1:0] c;
    logic [BIG_W-1:0] r;
    logic [BIG_W-1:0] p;
    logic [BIG_W-1:0] m;
    logic [T_W-1:0]   lo;
    logic [T_W-1:0]   hi;
    logic [T_W-1:0]   mid;
    c = BIG_W'(1);
    for (int i = 0; i < 12; i++) c = c * BIG_W'(53805);
    t[0] = '0;
    for (int k = 1; k < CODES; k++) begin
      r = BIG_W'(1);
      for (int i = 0; i < 12; i++) r = r * BIG_W'(200 * k + 2705);
      r = r << (10 * FRACTION_BITS);
      lo = '0;
      hi = T_W'(1) << X_W;
      for (int n = 0; n < T_W + 1; n++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          m = BIG_W'(mid);
          p = m * m;
          p = p * m;
          p = p * m;
          p = p * m;
          p = p * c;
          if (p >= r) hi = mid;
          else lo = mid + T_W'(1);
        end
      end
      t[k] = lo;
    end
    return t;
  endfunction

  // smallest product that reaches each code on the linear segment
  function automatic thr_tab_t build_lin_tab();
    thr_tab_t        t;
    longint unsigned v;
    t[0] = '0;
    for (int k = 1; k < CODES; k++) begin
      v = ((64'(10 * k - 5) << X_W) + 64'd32945) / 64'd32946;
      if (v >= (64'd1 << T_W)) t[k] = '1;
      else t[k] = T_W'(v);
    end
    return t;
  endfunction

  localparam thr_tab_t POW_T = build_pow_tab();
  localparam thr_tab_t LIN_T = build_lin_tab();

endpackage

// ===== src/l2s_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2s_lane
// one colour channel: gain product, then a bit-per-stage code search
// ----------------------------------------------------------------------------
module l2s_lane (
  input  logic                                   clk,
  input  logic [l2s_pkg::NSTAGE-1:0]             en,
  input  logic signed [l2s_pkg::SAMPLE_WIDTH-1:0] sample,
  input  l2s_pkg::cfg_t                          cfg,
  output logic [l2s_pkg::CODE_W-1:0]             code
);

  logic                           pos0;
  logic [l2s_pkg::MAG_W-1:0]      mag0;
  logic [l2s_pkg::PROD_W-1:0]     prod1;
  logic [l2s_pkg::FC_W-1:0]       fcn1;
  logic                           pos1;
  logic                           satfc1;
  l2s_pkg::srch_t                 srch_in;
  l2s_pkg::srch_t                 srch [1:l2s_pkg::NSRCH];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pos0 <= !sample[l2s_pkg::SAMPLE_WIDTH-1] && (sample != '0);
      mag0 <= sample[l2s_pkg::MAG_W-1:0];
    end
    if (en[1]) begin
      prod1  <= l2s_pkg::PROD_W'(mag0) * l2s_pkg::PROD_W'(cfg.exposure_gain);
      fcn1   <= l2s_pkg::FC_W'(mag0) * l2s_pkg::FC_W'(510);
      satfc1 <= l2s_pkg::PROD_W'(mag0) >= l2s_pkg::PROD_W'(cfg.peak_level);
      pos1   <= pos0;
    end
  end

  always_comb begin
    srch_in.x      = prod1[l2s_pkg::X_W-1:0];
    srch_in.pos    = pos1;
    srch_in.fc_num = fcn1;
    srch_in.acc    = '0;
    srch_in.sat    = cfg.preview_mode ? (|prod1[l2s_pkg::PROD_W-1:l2s_pkg::X_W]) : satfc1;
    if (!cfg.preview_mode) begin
      srch_in.kind = l2s_pkg::KIND_FC;
    end else if (prod1[l2s_pkg::X_W-1:0] <= l2s_pkg::LIN_LIM) begin
      srch_in.kind = l2s_pkg::KIND_LIN;
    end else begin
      srch_in.kind = l2s_pkg::KIND_POW;
    end
  end

  for (genvar j = 1; j <= l2s_pkg::NSRCH; j++) begin : g_srch
    l2s_pkg::srch_t                prev;
    l2s_pkg::srch_t                nxt;
    logic [l2s_pkg::CODE_W-1:0]    cand;
    logic [l2s_pkg::CMP_W-1:0]     fc_rhs;
    logic                          hit;

    if (j == 1) begin : g_first
      assign prev = srch_in;
    end else begin : g_next
      assign prev = srch[j-1];
    end

    assign cand   = prev.acc | (l2s_pkg::CODE_W'(1) << (l2s_pkg::NSRCH - j));
    // code c is reached when 510*s >= (2c-1)*peak
    assign fc_rhs = l2s_pkg::CMP_W'({cand, 1'b0} - (l2s_pkg::CODE_W + 1)'(1))
                  * l2s_pkg::CMP_W'(cfg.peak_level);

    always_comb begin
      unique case (prev.kind)
        l2s_pkg::KIND_LIN: hit = {1'b0, prev.x} >= l2s_pkg::LIN_T[cand];
        l2s_pkg::KIND_POW: hit = {1'b0, prev.x} >= l2s_pkg::POW_T[cand];
        l2s_pkg::KIND_FC:  hit = l2s_pkg::CMP_W'(prev.fc_num) >= fc_rhs;
        default:           hit = 1'b0;
      endcase
    end

    always_comb begin
      nxt     = prev;
      nxt.acc = hit ? cand : prev.acc;
    end

    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        srch[j] <= nxt;
      end
    end
  end

  assign code = !srch[l2s_pkg::NSRCH].pos ? '0 :
                 srch[l2s_pkg::NSRCH].sat ? '1 : srch[l2s_pkg::NSRCH].acc;

endmodule

// ===== src/linear_to_srgb8_pixel_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_to_srgb8_pixel_encoder_core
// three linear samples in, three 8-bit srgb or false-colour codes out
//
//  channel  dir  beat                                 handshake
//  s_*      in   tdata: red, green, blue linear 32b   tvalid/tready
//  m_*      out  tdata: red, green, blue code 8b      tvalid/tready
//  cfg_*    in   register index and data              cfg_we, no wait
//
// one pixel per clock while m_tready takes the output beats; new beats enter before older ones leave
// a beat passes the input register, the gain multiply, one stage per code bit and the output register
// every stage moves on when the next one is empty or moving on, so bubbles close up
// rst clears the pipeline and loads the register reset values
// ----------------------------------------------------------------------------
module linear_to_srgb8_pixel_encoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [l2s_pkg::S_TDATA_W-1:0]   s_tdata,  // red, green, blue linear
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [l2s_pkg::M_TDATA_W-1:0]   m_tdata,  // red, green, blue code
  input  logic                            cfg_we,
  input  logic [l2s_pkg::IDX_W-1:0]       cfg_index,
  input  logic [l2s_pkg::CFG_W-1:0]       cfg_data
);

  l2s_pkg::cfg_t                   cfg;
  logic [l2s_pkg::NSTAGE:0]        v;
  logic [l2s_pkg::NSTAGE:0]        rdy;
  logic [l2s_pkg::NSTAGE:0]        en;
  logic [l2s_pkg::CODE_W-1:0]      code [l2s_pkg::LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preview_mode  <= 1'b1;
      cfg.exposure_gain <= l2s_pkg::GAIN_RESET;
      cfg.peak_level    <= l2s_pkg::PEAK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        l2s_pkg::REG_PREVIEW_MODE:  cfg.preview_mode  <= cfg_data[0];
        l2s_pkg::REG_EXPOSURE_GAIN: cfg.exposure_gain <= cfg_data;
        l2s_pkg::REG_PEAK_LEVEL:    cfg.peak_level    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[l2s_pkg::NSTAGE] = !v[l2s_pkg::NSTAGE] || m_tready;
    for (int i = l2s_pkg::NSTAGE - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
    en[0] = s_tvalid && rdy[0];
    for (int i = 1; i <= l2s_pkg::NSTAGE; i++) begin
      en[i] = v[i-1] && rdy[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= en | (v & ~rdy);
    end
  end

  for (genvar l = 0; l < l2s_pkg::LANES; l++) begin : g_lane
    l2s_lane u_lane (
      .clk    (clk),
      .en     (en[l2s_pkg::NSTAGE-1:0]),
      .sample (s_tdata[l*l2s_pkg::SAMPLE_WIDTH +: l2s_pkg::SAMPLE_WIDTH]),
      .cfg    (cfg),
      .code   (code[l])
    );
  end

  // merge the three lane codes into one output beat
  always_ff @(posedge clk) begin
    if (en[l2s_pkg::NSTAGE]) begin
      m_tdata <= l2s_pkg::M_TDATA_W'({code[2], code[1], code[0]});
    end
  end

  assign m_tvalid = v[l2s_pkg::NSTAGE];
  assign s_tready = rdy[0];

endmodule

// ===== src/l2s_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2s_checker
// port-level checks on the encoder core, bound to the top level
// ----------------------------------------------------------------------------
`include "linear_to_srgb8_pixel_encoder_core_defines.svh"

module l2s_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [l2s_pkg::M_TDATA_W-1:0]   m_tdata
);

  `L2S_ASSERT_RESET(a_reset_empty, rst, !m_tvalid)
  `L2S_ASSERT_SAME(a_taken_frees_input, m_tready || !m_tvalid, s_tready)
  `L2S_ASSERT_NEXT(a_stall_holds_valid, m_tvalid && !m_tready, m_tvalid)
  `L2S_ASSERT_NEXT(a_stall_holds_data, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind linear_to_srgb8_pixel_encoder_core l2s_checker u_l2s_checker (.*);
